FILE: design/urzc_pkg.sv
// Package for the ultrasonic range zone controller: phase and zone codes,
// register map, reset values and the constants of the distance conversion.
// No dependencies.
`timescale 1ns / 1ps

package urzc_pkg;

    // Measurement phases
    typedef enum logic [2:0] {
        PH_SETTLE  = 3'd0,
        PH_TRIG    = 3'd1,
        PH_WAIT    = 3'd2,
        PH_MEASURE = 3'd3,
        PH_IDLE    = 3'd4
    } phase_t;

    // Distance zones; ZONE_NONE marks "no measurement yet"
    typedef enum logic [1:0] {
        ZONE_WARN    = 2'd0,
        ZONE_CAUTION = 2'd1,
        ZONE_NORMAL  = 2'd2,
        ZONE_NONE    = 2'd3
    } zone_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TRIG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_ECHO_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_PERIOD       = 3'd2;
    localparam logic [2:0] REG_WARN         = 3'd3;
    localparam logic [2:0] REG_CAUTION      = 3'd4;

    // Register reset values
    localparam logic [7:0]  TRIG_WIDTH_RST   = 8'd10;
    localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd30000;
    localparam logic [15:0] PERIOD_RST       = 16'd60000;
    localparam logic [9:0]  WARN_RST         = 10'd5;
    localparam logic [9:0]  CAUTION_RST      = 10'd10;

    // Timing and conversion constants
    localparam logic [31:0] SETTLE_TICKS = 32'd2;
    localparam int unsigned CM_DIVISOR   = 58;
    localparam logic [9:0]  FAR_CM       = 10'd999;
    // Widths at or above this convert to more than 999 cm
    localparam logic [31:0] FAR_WIDTH    = 32'(CM_DIVISOR * 1000);
    // width / 58 == (width * RECIP_MULT) >> RECIP_SHIFT for width < FAR_WIDTH
    localparam int unsigned RECIP_SHIFT  = 22;
    localparam logic [16:0] RECIP_MULT   = 17'(((1 << RECIP_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR);

endpackage

FILE: design/ultrasonic_range_zone_controller.sv
// Top level of the ultrasonic range zone controller: tick stream in, one
// status beat out per tick, APB register port. Depends on urzc_pkg.
`timescale 1ns / 1ps

//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata[0] echo_level, one beat a tick
//  m_*      | out | m_tvalid/m_tready  | m_tdata status word, one beat per tick
//  APB      | in  | psel/penable/pready| five config registers at 4*index
//
//  The phase counter and the divide by 58 (one 16x17 multiply) sit between
//  the state registers and the output register.
//  The output register lets a new tick in whenever it is empty or being taken.
//  Reset is asynchronous and active low; it clears phase, counter, zone
//  history, output valid and loads the register reset values.
//  A stalled output holds its beat and stops input until it is taken.

module ultrasonic_range_zone_controller #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // tick stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] echo_level, [7:1] zero
    // status stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] trigger_level, [1] result_valid,
                                    // [11:2] distance_cm, [13:12] zone,
                                    // [14] zone_changed, [15] no_echo
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    // Configuration registers
    logic [7:0]  trig_width_reg;
    logic [15:0] echo_timeout_reg;
    logic [15:0] period_reg;
    logic [9:0]  warn_reg;
    logic [9:0]  caution_reg;

    // Measurement state
    urzc_pkg::phase_t         phase_reg, phase_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    urzc_pkg::zone_t          last_zone_reg, last_zone_next;
    logic [9:0]               last_dist_reg, last_dist_next;

    // Output register
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic                     accept;
    logic                     echo;
    logic                     cfg_wr;
    logic [COUNTER_WIDTH-1:0] cnt_bump;
    logic                     bump_expired;
    logic                     one_expired;
    logic [7:0]               trig_eff;
    logic                     fin;
    logic                     fin_none;
    logic [COUNTER_WIDTH-1:0] fin_width;
    logic                     trig_out;
    logic [31:0]              width32;
    logic [32:0]              prod;
    logic [9:0]               quot;
    logic [9:0]               dist_cm;
    urzc_pkg::zone_t          zone_new;
    urzc_pkg::zone_t          zone_shown;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign echo     = s_tdata[0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width_reg   <= urzc_pkg::TRIG_WIDTH_RST;
            echo_timeout_reg <= urzc_pkg::ECHO_TIMEOUT_RST;
            period_reg       <= urzc_pkg::PERIOD_RST;
            warn_reg         <= urzc_pkg::WARN_RST;
            caution_reg      <= urzc_pkg::CAUTION_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                urzc_pkg::REG_TRIG_WIDTH:   trig_width_reg   <= pwdata[7:0];
                urzc_pkg::REG_ECHO_TIMEOUT: echo_timeout_reg <= pwdata[15:0];
                urzc_pkg::REG_PERIOD:       period_reg       <= pwdata[15:0];
                urzc_pkg::REG_WARN:         warn_reg         <= pwdata[9:0];
                urzc_pkg::REG_CAUTION:      caution_reg      <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[4:2])
            urzc_pkg::REG_TRIG_WIDTH:   prdata = 32'(trig_width_reg);
            urzc_pkg::REG_ECHO_TIMEOUT: prdata = 32'(echo_timeout_reg);
            urzc_pkg::REG_PERIOD:       prdata = 32'(period_reg);
            urzc_pkg::REG_WARN:         prdata = 32'(warn_reg);
            urzc_pkg::REG_CAUTION:      prdata = 32'(caution_reg);
            default:                    prdata = '0;
        endcase
    end

    // Saturating tick count and timeout tests
    assign cnt_bump     = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNTER_WIDTH'(1);
    assign bump_expired = (32'(cnt_bump) > 32'(echo_timeout_reg)) || (cnt_bump == CNT_MAX);
    assign one_expired  = (echo_timeout_reg == 16'd0);
    assign trig_eff     = (trig_width_reg == 8'd0) ? 8'd1 : trig_width_reg;

    // Phase sequencing: next state
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        fin        = 1'b0;
        fin_none   = 1'b0;
        fin_width  = cnt_reg;
        trig_out   = 1'b0;
        case (phase_reg)
            urzc_pkg::PH_SETTLE:
            begin
                if (32'(cnt_bump) >= urzc_pkg::SETTLE_TICKS)
                begin
                    phase_next = urzc_pkg::PH_TRIG;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_bump;
                end
            end
            urzc_pkg::PH_TRIG:
            begin
                trig_out = 1'b1;
                if (32'(cnt_bump) >= 32'(trig_eff))
                begin
                    phase_next = urzc_pkg::PH_WAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_bump;
                end
            end
            urzc_pkg::PH_WAIT:
            begin
                if (echo)
                begin
                    // first high tick counts as width 1
                    phase_next = urzc_pkg::PH_MEASURE;
                    cnt_next   = COUNTER_WIDTH'(1);
                    fin        = one_expired;
                    fin_width  = COUNTER_WIDTH'(1);
                end
                else
                begin
                    cnt_next = cnt_bump;
                    fin      = bump_expired;
                    fin_none = 1'b1;
                end
            end
            urzc_pkg::PH_MEASURE:
            begin
                if (echo)
                begin
                    cnt_next  = cnt_bump;
                    fin       = bump_expired;
                    fin_width = cnt_bump;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            urzc_pkg::PH_IDLE:
            begin
                if (32'(cnt_bump) >= 32'(period_reg))
                begin
                    phase_next = urzc_pkg::PH_SETTLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_bump;
                end
            end
            default:
            begin
                phase_next = urzc_pkg::PH_SETTLE;
                cnt_next   = '0;
            end
        endcase
        if (fin)
        begin
            cnt_next   = '0;
            phase_next = (period_reg == 16'd0) ? urzc_pkg::PH_SETTLE : urzc_pkg::PH_IDLE;
        end
    end

    // Width to centimeters: reciprocal multiply; 999 for no echo, over 999 cm or under 1 cm
    assign width32 = 32'(fin_width);
    assign prod    = 33'(width32[15:0]) * 33'(urzc_pkg::RECIP_MULT);
    assign quot    = prod[urzc_pkg::RECIP_SHIFT +: 10];
    assign dist_cm = (fin_none || width32 >= urzc_pkg::FAR_WIDTH || quot == 10'd0)
                     ? urzc_pkg::FAR_CM : quot;

    // Zone of the new distance; warning test first
    always_comb
    begin
        if (dist_cm <= warn_reg)
            zone_new = urzc_pkg::ZONE_WARN;
        else if (dist_cm <= caution_reg)
            zone_new = urzc_pkg::ZONE_CAUTION;
        else
            zone_new = urzc_pkg::ZONE_NORMAL;
    end

    // Status word and zone history: outputs
    always_comb
    begin
        last_zone_next = last_zone_reg;
        last_dist_next = last_dist_reg;
        zone_shown     = (last_zone_reg == urzc_pkg::ZONE_NONE)
                         ? urzc_pkg::ZONE_NORMAL : last_zone_reg;
        m_tdata_next   = {1'b0, 1'b0, zone_shown, last_dist_reg, 1'b0, trig_out};
        if (fin)
        begin
            last_zone_next = zone_new;
            last_dist_next = dist_cm;
            m_tdata_next   = {fin_none, (zone_new != last_zone_reg), zone_new, dist_cm,
                              1'b1, trig_out};
        end
    end

    // State update, one tick per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= urzc_pkg::PH_SETTLE;
            cnt_reg       <= '0;
            last_zone_reg <= urzc_pkg::ZONE_NONE;
            last_dist_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            last_zone_reg <= last_zone_next;
            last_dist_reg <= last_dist_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

FILE: design/urzc_checker.sv
// Port-level checks for the ultrasonic range zone controller, bound to the
// top level. No package dependencies.
`timescale 1ns / 1ps

module urzc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    // An empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output empty");

    // A finished measurement carries a distance of 1 to 999
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[11:2] != 10'd0 && m_tdata[11:2] <= 10'd999)
        else $error("finished distance out of range");

    // Zone-change and no-echo flags only on a finishing beat, zone never 3
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> !m_tdata[14] && !m_tdata[15])
        else $error("result flag without finished measurement");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[13:12] != 2'd3)
        else $error("zone code 3 on output");

endmodule

bind ultrasonic_range_zone_controller urzc_checker u_urzc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: bench/ultrasonic_range_zone_controller_test.sv
// Self-checking bench for ultrasonic_range_zone_controller: drives echo ticks and
// APB register writes, predicts every status beat and checks it field by field.
// Depends on urzc_pkg and the controller RTL.
`timescale 1ns / 1ps

module ultrasonic_range_zone_controller_test;

    localparam int              COUNTER_BITS = 16;
    localparam longint unsigned CNT_MAX      = (64'd1 << COUNTER_BITS) - 1;
    localparam int unsigned     CYCLE_LIMIT  = 100000;
    localparam int unsigned     MAX_REPORTS  = 40;

    // Status beat as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic       no_echo;
        logic       zone_changed;
        logic [1:0] zone;
        logic [9:0] distance;
        logic       done;
        logic       trigger;
    } status_t;

    // Predicts one status beat per tick and checks the beats that come out
    class range_scoreboard;
        logic [7:0]        trig_width;
        logic [15:0]       echo_timeout;
        logic [15:0]       period;
        logic [9:0]        warn_cm;
        logic [9:0]        caution_cm;
        urzc_pkg::phase_t  phase;
        longint unsigned   count;
        urzc_pkg::zone_t   last_zone;
        logic [9:0]        last_dist;
        status_t           pending_status[$];
        int unsigned       ticks;
        int unsigned       measurements;
        int unsigned       no_echo_hits;
        int unsigned       far_hits;
        int unsigned       zone_flips;
        int unsigned       errors;
        int unsigned       zone_hits[3];

        function new();
            trig_width   = urzc_pkg::TRIG_WIDTH_RST;
            echo_timeout = urzc_pkg::ECHO_TIMEOUT_RST;
            period       = urzc_pkg::PERIOD_RST;
            warn_cm      = urzc_pkg::WARN_RST;
            caution_cm   = urzc_pkg::CAUTION_RST;
            phase        = urzc_pkg::PH_SETTLE;
            count        = 0;
            last_zone    = urzc_pkg::ZONE_NONE;
            last_dist    = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                urzc_pkg::REG_TRIG_WIDTH:   trig_width   = value[7:0];
                urzc_pkg::REG_ECHO_TIMEOUT: echo_timeout = value[15:0];
                urzc_pkg::REG_PERIOD:       period       = value[15:0];
                urzc_pkg::REG_WARN:         warn_cm      = value[9:0];
                urzc_pkg::REG_CAUTION:      caution_cm   = value[9:0];
                default:                    ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                urzc_pkg::REG_TRIG_WIDTH:   return {24'd0, trig_width};
                urzc_pkg::REG_ECHO_TIMEOUT: return {16'd0, echo_timeout};
                urzc_pkg::REG_PERIOD:       return {16'd0, period};
                urzc_pkg::REG_WARN:         return {22'd0, warn_cm};
                urzc_pkg::REG_CAUTION:      return {22'd0, caution_cm};
                default:                    return '0;
            endcase
        endfunction

        // Counter step, saturating at the counter's top value
        function longint unsigned bump();
            return (count + 1 > CNT_MAX) ? CNT_MAX : count + 1;
        endfunction

        function bit expired(longint unsigned n);
            return (n > echo_timeout) || (n >= CNT_MAX);
        endfunction

        // Width to centimetres, clamp, zone and history update
        function void finish_measurement(longint unsigned width, bit none, inout status_t st);
            longint unsigned d;
            urzc_pkg::zone_t z;
            d = none ? 64'd0 : width / urzc_pkg::CM_DIVISOR;
            if (d == 0 || d > 64'(urzc_pkg::FAR_CM))
                d = 64'(urzc_pkg::FAR_CM);
            if (d <= warn_cm)
                z = urzc_pkg::ZONE_WARN;
            else if (d <= caution_cm)
                z = urzc_pkg::ZONE_CAUTION;
            else
                z = urzc_pkg::ZONE_NORMAL;
            st.done         = 1'b1;
            st.distance     = d[9:0];
            st.zone         = z;
            st.zone_changed = (z != last_zone);
            st.no_echo      = none;
            measurements++;
            zone_hits[z]++;
            if (none)
                no_echo_hits++;
            if (d == 64'(urzc_pkg::FAR_CM))
                far_hits++;
            if (z != last_zone)
                zone_flips++;
            last_zone = z;
            last_dist = d[9:0];
            count     = 0;
            phase     = (period == 16'd0) ? urzc_pkg::PH_SETTLE : urzc_pkg::PH_IDLE;
        endfunction

        // One accepted tick: queue its status beat, return the done flag
        function bit note_tick(bit echo);
            status_t         st;
            longint unsigned n;
            longint unsigned tw;
            st          = '0;
            st.distance = last_dist;
            st.zone     = (last_zone == urzc_pkg::ZONE_NONE) ? urzc_pkg::ZONE_NORMAL : last_zone;
            tw          = (trig_width == 8'd0) ? 64'd1 : 64'(trig_width);
            ticks++;
            case (phase)
                urzc_pkg::PH_SETTLE:
                begin
                    n = bump();
                    if (n >= urzc_pkg::SETTLE_TICKS)
                    begin
                        phase = urzc_pkg::PH_TRIG;
                        count = 0;
                    end
                    else
                        count = n;
                end
                urzc_pkg::PH_TRIG:
                begin
                    st.trigger = 1'b1;
                    n = bump();
                    if (n >= tw)
                    begin
                        phase = urzc_pkg::PH_WAIT;
                        count = 0;
                    end
                    else
                        count = n;
                end
                urzc_pkg::PH_WAIT:
                begin
                    if (echo)
                    begin
                        // first high tick already counts as width 1
                        phase = urzc_pkg::PH_MEASURE;
                        count = 1;
                        if (expired(1))
                            finish_measurement(1, 1'b0, st);
                    end
                    else
                    begin
                        n     = bump();
                        count = n;
                        if (expired(n))
                            finish_measurement(0, 1'b1, st);
                    end
                end
                urzc_pkg::PH_MEASURE:
                begin
                    if (echo)
                    begin
                        n     = bump();
                        count = n;
                        if (expired(n))
                            finish_measurement(n, 1'b0, st);
                    end
                    else
                        finish_measurement(count, 1'b0, st);
                end
                urzc_pkg::PH_IDLE:
                begin
                    n = bump();
                    if (n >= period)
                    begin
                        phase = urzc_pkg::PH_SETTLE;
                        count = 0;
                    end
                    else
                        count = n;
                end
                default:
                begin
                    phase = urzc_pkg::PH_SETTLE;
                    count = 0;
                end
            endcase
            pending_status.push_back(st);
            return st.done;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got,
                                  inout bit bad);
            if (want != got)
            begin
                bad = 1'b1;
                if (errors < MAX_REPORTS)
                    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_status(status_t got);
            status_t want;
            bit      bad;
            if (pending_status.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: status beat %h with no tick pending", $time, got);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            bad  = 1'b0;
            check_field("trigger_level", 32'(want.trigger), 32'(got.trigger), bad);
            check_field("result_valid", 32'(want.done), 32'(got.done), bad);
            check_field("distance_cm", 32'(want.distance), 32'(got.distance), bad);
            check_field("zone", 32'(want.zone), 32'(got.zone), bad);
            check_field("zone_changed", 32'(want.zone_changed), 32'(got.zone_changed), bad);
            check_field("no_echo", 32'(want.no_echo), 32'(got.no_echo), bad);
            if (bad)
                errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [0] echo_level, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [0] trigger_level, [1] result_valid, [11:2] distance_cm,
                              // [13:12] zone, [14] zone_changed, [15] no_echo
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    range_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    ultrasonic_range_zone_controller #(
        .COUNTER_WIDTH(COUNTER_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                m_tready  = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Output monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_status(m_tdata);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached, %0d status beats outstanding",
                 $time, sb.pending_status.size());
        $display("ultrasonic_range_zone_controller regression: fail");
        $finish;
    end

    // One tick beat; called and returns at a falling edge
    task automatic send_tick(input bit echo, output bit done);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, echo};
        do
            @(posedge clk);
        while (!s_tready);
        done = sb.note_tick(echo);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // APB write, then read back the same register
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== sb.reg_value(idx))
        begin
            sb.errors++;
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, idx, sb.reg_value(idx), readback);
        end
    endtask

    task automatic write_all(input logic [7:0] tw, input logic [15:0] timeout,
                             input logic [15:0] per, input logic [9:0] warn,
                             input logic [9:0] caution);
        write_reg(urzc_pkg::REG_TRIG_WIDTH, 32'(tw));
        write_reg(urzc_pkg::REG_ECHO_TIMEOUT, 32'(timeout));
        write_reg(urzc_pkg::REG_PERIOD, 32'(per));
        write_reg(urzc_pkg::REG_WARN, 32'(warn));
        write_reg(urzc_pkg::REG_CAUTION, 32'(caution));
    endtask

    // Sender pause until every status beat has come out
    task automatic wait_drain();
        while (sb.pending_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Ticks until one measurement finishes; echo goes high `delay` ticks into the
    // wait phase and stays high for `width` ticks, with optional random flips
    task automatic run_measurement(input int unsigned delay, input int unsigned width,
                                   input int unsigned noise_pct);
        int unsigned k;
        bit          echo;
        bit          done;
        bit          in_window;
        k    = 0;
        done = 1'b0;
        while (!done)
        begin
            in_window = (sb.phase == urzc_pkg::PH_WAIT) || (sb.phase == urzc_pkg::PH_MEASURE);
            echo      = in_window && (k >= delay) && (k - delay < width);
            if ($urandom_range(99) < noise_pct)
                echo = !echo;
            if (in_window)
                k++;
            send_tick(echo, done);
        end
    endtask

    task automatic random_measurement();
        int unsigned delay;
        int unsigned width;
        int unsigned roll;
        int unsigned to;
        int unsigned noise;
        to   = 32'(sb.echo_timeout);
        roll = $urandom_range(99);
        if (roll < 75)
            delay = $urandom_range(20, 0);
        else if (roll < 90)
            delay = $urandom_range(to + 3, 0);
        else
            delay = to + 10;
        roll = $urandom_range(99);
        if (roll < 45)
            width = $urandom_range(58 * (32'(sb.caution_cm) + 3), 0);
        else if (roll < 70)
            width = $urandom_range(60, 0);
        else if (roll < 85)
            width = $urandom_range(to + 3, (to > 3) ? to - 3 : 0);
        else
            width = $urandom_range(1200, 0);
        noise = ($urandom_range(99) < 15) ? 3 : 0;
        run_measurement(delay, width, noise);
    endtask

    task automatic random_config();
        int unsigned roll;
        logic [7:0]  tw;
        logic [15:0] timeout;
        logic [15:0] per;
        roll = $urandom_range(99);
        tw   = (roll < 10) ? 8'd0 : (roll < 15) ? 8'd255 : 8'($urandom_range(6, 1));
        roll = $urandom_range(99);
        timeout = (roll < 10) ? 16'($urandom_range(8, 1)) : 16'($urandom_range(160, 40));
        roll = $urandom_range(99);
        per  = (roll < 25) ? 16'd0 : 16'($urandom_range(25, 1));
        write_all(tw, timeout, per, 10'($urandom_range(2, 0)), 10'($urandom_range(3, 0)));
    endtask

    // Random phase with its own idling; `pressure` adds a long receiver hold-off
    // and one sender pause until the output has drained
    task automatic random_phase(input int unsigned send_pct, input int unsigned stall,
                                input bit pressure);
        int unsigned start_ticks;
        int unsigned start_meas;
        bit          paused;
        send_idle_pct = send_pct;
        stall_pct     = stall;
        random_config();
        start_ticks = sb.ticks;
        start_meas  = sb.measurements;
        paused      = 1'b0;
        if (pressure)
            hold_req = 400;
        while (sb.ticks - start_ticks < 100 || sb.measurements - start_meas < 2)
        begin
            random_measurement();
            if (pressure && !paused && sb.measurements - start_meas >= 1)
            begin
                wait_drain();
                paused = 1'b1;
            end
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, first measurement always flags a zone change
        run_measurement(3, 120, 0);
        wait_drain();

        // Zero trigger width, zero period, timeout of 1: echo at first wait tick,
        // then no echo at all
        write_all(8'd0, 16'd1, 16'd0, 10'd0, 10'd0);
        run_measurement(0, 5, 0);
        run_measurement(5, 0, 0);
        wait_drain();

        // Conversion edges and zone boundaries (warning up to 1 cm, caution up to 2 cm)
        write_all(8'd1, 16'd30000, 16'd1, 10'd1, 10'd2);
        run_measurement(2, 57, 0);
        run_measurement(2, 58, 0);
        run_measurement(2, 58 * 2, 0);
        run_measurement(2, 58 * 2 + 57, 0);
        run_measurement(2, 58 * 3, 0);
        wait_drain();

        // Warning threshold above caution leaves no caution zone
        write_reg(urzc_pkg::REG_WARN, 32'd3);
        run_measurement(1, 58 * 2, 0);
        run_measurement(1, 58 * 4, 0);
        wait_drain();

        // Width ending just at and just past the timeout
        write_reg(urzc_pkg::REG_ECHO_TIMEOUT, 32'd60);
        run_measurement(0, 60, 0);
        run_measurement(0, 61, 0);
        wait_drain();

        // Random phases with different idling
        random_phase(0, 0, 1'b0);
        random_phase(54, 0, 1'b0);
        random_phase(0, 54, 1'b0);
        random_phase(26, 26, 1'b0);
        random_phase(0, 0, 1'b1);

        wait_drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d ticks, %0d measurements (%0d without echo, %0d at 999 cm),",
                 sb.ticks, sb.measurements, sb.no_echo_hits, sb.far_hits);
        $display("zones warning/caution/normal %0d/%0d/%0d, %0d zone changes, %0d errors",
                 sb.zone_hits[0], sb.zone_hits[1], sb.zone_hits[2], sb.zone_flips, sb.errors);
        if (sb.pending_status.size() != 0)
            $display("%0t: %0d status beats never arrived", $time, sb.pending_status.size());
        if (sb.errors == 0 && sb.pending_status.size() == 0)
            $display("ultrasonic_range_zone_controller regression: pass");
        else
            $display("ultrasonic_range_zone_controller regression: fail");
        $finish;
    end

endmodule

FILE: files.f
design/urzc_pkg.sv
design/ultrasonic_range_zone_controller.sv
design/urzc_checker.sv
bench/ultrasonic_range_zone_controller_test.sv
